// ----- hdl/vertex_transform_with_divide_macros.svh -----
// ============================================================================
// vertex_transform_with_divide_macros.svh
// Assertion macros for the checker file of the vertex transform.
// ============================================================================
`ifndef VERTEX_TRANSFORM_WITH_DIVIDE_MACROS_SVH
`define VERTEX_TRANSFORM_WITH_DIVIDE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define VTD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define VTD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vtd_pkg.sv -----
// ============================================================================
// vtd_pkg
// Shared constants for the vertex transform and its divider.
// ============================================================================
package vtd_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

endpackage

// ----- hdl/vtd_div.sv -----
// ============================================================================
// vtd_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ============================================================================
module vtd_div #(
    parameter int NW = 49
) (
    input  logic                          clk,
    input  logic [NW-1:0]                 dividend,
    input  logic [vtd_pkg::DATA_W-1:0]    divisor,
    output logic [NW-1:0]                 quotient
);

    localparam int DW = vtd_pkg::DATA_W;

    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] num_next [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [NW-1:0] quo_next [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [DW-1:0] den_next [NW];

    always_comb
    begin
        logic [DW-1:0] rem_prev;
        logic [NW-1:0] num_prev;
        logic [NW-1:0] quo_prev;
        logic [DW-1:0] den_prev;
        logic [DW:0]   trial;
        logic          ge;
        for (int i = 0; i < NW; i++)
        begin
            if (i == 0)
            begin
                rem_prev = '0;
                num_prev = dividend;
                quo_prev = '0;
                den_prev = divisor;
            end
            else
            begin
                rem_prev = rem_reg[i-1];
                num_prev = num_reg[i-1];
                quo_prev = quo_reg[i-1];
                den_prev = den_reg[i-1];
            end
            trial = {rem_prev, num_prev[NW-1]};
            ge    = (trial >= {1'b0, den_prev});
            if (ge)
            begin
                rem_next[i] = DW'(trial - {1'b0, den_prev});
            end
            else
            begin
                rem_next[i] = trial[DW-1:0];
            end
            num_next[i] = num_prev << 1;
            quo_next[i] = {quo_prev[NW-2:0], ge};
            den_next[i] = den_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NW; i++)
        begin
            rem_reg[i] <= rem_next[i];
            num_reg[i] <= num_next[i];
            quo_reg[i] <= quo_next[i];
            den_reg[i] <= den_next[i];
        end
    end

    assign quotient = quo_reg[NW-1];

endmodule

// ----- hdl/vertex_transform_with_divide.sv -----
// ============================================================================
// vertex_transform_with_divide
// 4x4 fixed-point vertex transform with optional perspective divide.
// ============================================================================
// Throughput: one request per clock; busy is tied low, nothing ever stalls.
// Depth is set by the bit-serial divider pipeline (33+FRAC_BITS stages).
// Reset: rst_n clears the valid line and loads the identity matrix.
// Results are shown on done for a single cycle; the receiver cannot stall.
module vertex_transform_with_divide #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                in_x,
    input  logic signed [31:0]                in_y,
    input  logic signed [31:0]                in_z,
    input  logic signed [31:0]                in_w,
    input  logic                              row_vector,
    input  logic                              project,
    // result side
    output logic                              done,
    output logic signed [31:0]                out_x,
    output logic signed [31:0]                out_y,
    output logic signed [31:0]                out_z,
    output logic signed [31:0]                out_w,
    output logic                              zero_divisor,
    output logic                              saturated,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DW = vtd_pkg::DATA_W;
    // Divider dividend: |num| << FRAC_BITS plus half the divisor.
    localparam int NW = DW + 1 + FRAC_BITS;

    localparam logic [DW-1:0]        ONE    = DW'(1) << FRAC_BITS;
    localparam logic signed [65:0]   HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0]   MAX66  = 66'sd2147483647;
    localparam logic signed [65:0]   MIN66  = -66'sd2147483648;
    localparam logic [DW-1:0]        MAX32  = 32'h7FFF_FFFF;
    localparam logic [DW-1:0]        MIN32  = 32'h8000_0000;
    localparam logic [NW-1:0]        QMAX_P = NW'(32'h7FFF_FFFF);
    localparam logic [NW-1:0]        QMAX_N = NW'(32'h8000_0000);

    // Items travel with what the final stage needs while the divider runs.
    typedef struct packed {
        logic [3:0][DW-1:0] res;
        logic               proj;
        logic               sat;
        logic [2:0]         neg;
        logic               zero;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; indexes past seven dropped.
    // ------------------------------------------------------------------
    logic [vtd_pkg::CFG_W-1:0] cfg_reg [vtd_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity: diagonal entries sit alternately in low and high halves
            cfg_reg[0] <= {32'd0, ONE};
            cfg_reg[1] <= '0;
            cfg_reg[2] <= {ONE, 32'd0};
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= {32'd0, ONE};
            cfg_reg[6] <= '0;
            cfg_reg[7] <= {ONE, 32'd0};
        end
        else if (cfg_valid && cfg_ready &&
                 (cfg_index < vtd_pkg::CFG_IDX_W'(vtd_pkg::NUM_REGS)))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: pick coefficients for the requested order, capture vertex.
    // ------------------------------------------------------------------
    logic [DW-1:0] mat [4][4];
    logic signed [DW-1:0] coef_next [4][4];
    logic signed [DW-1:0] coef_reg  [4][4];
    logic signed [DW-1:0] vec_next  [4];
    logic signed [DW-1:0] vec_reg   [4];
    logic                 proj1_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = cfg_reg[r*2 + c/2][32*(c%2) +: 32];
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef_next[r][c] = row_vector ? mat[c][r] : mat[r][c];
            end
        end
        vec_next[0] = in_x;
        vec_next[1] = in_y;
        vec_next[2] = in_z;
        vec_next[3] = project ? ONE : in_w;   // w taken as one when projecting
    end

    always_ff @(posedge clk)
    begin
        coef_reg  <= coef_next;
        vec_reg   <= vec_next;
        proj1_reg <= project;
    end

    // ------------------------------------------------------------------
    // Stage 2: sixteen exact 32x32 products.
    // ------------------------------------------------------------------
    logic signed [63:0] prod_reg [4][4];
    logic               proj2_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[r][c] <= coef_reg[r][c] * vec_reg[c];
            end
        end
        proj2_reg <= proj1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: pair sums. Stage 4: full sum plus rounding half.
    // ------------------------------------------------------------------
    logic signed [64:0] pair_reg [4][2];
    logic signed [65:0] tot_reg  [4];
    logic               proj3_reg;
    logic               proj4_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            pair_reg[r][0] <= {prod_reg[r][0][63], prod_reg[r][0]}
                            + {prod_reg[r][1][63], prod_reg[r][1]};
            pair_reg[r][1] <= {prod_reg[r][2][63], prod_reg[r][2]}
                            + {prod_reg[r][3][63], prod_reg[r][3]};
            tot_reg[r]     <= {pair_reg[r][0][64], pair_reg[r][0]}
                            + {pair_reg[r][1][64], pair_reg[r][1]} + HALF;
        end
        proj3_reg <= proj2_reg;
        proj4_reg <= proj3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: scale down (ties toward plus infinity) and clip.
    // ------------------------------------------------------------------
    logic signed [65:0]   scaled [4];
    logic signed [DW-1:0] res_next [4];
    logic [3:0]           clip_next;
    logic signed [DW-1:0] res_reg  [4];
    logic                 sat5_reg;
    logic                 proj5_reg;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            scaled[r] = tot_reg[r] >>> FRAC_BITS;
            if (scaled[r] > MAX66)
            begin
                res_next[r]  = MAX32;
                clip_next[r] = 1'b1;
            end
            else if (scaled[r] < MIN66)
            begin
                res_next[r]  = MIN32;
                clip_next[r] = 1'b1;
            end
            else
            begin
                res_next[r]  = scaled[r][DW-1:0];
                clip_next[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        sat5_reg  <= |clip_next;
        proj5_reg <= proj4_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes and rounded dividend for the divide.
    // ------------------------------------------------------------------
    logic [DW-1:0] den_mag;
    logic [DW-1:0] num_mag  [3];
    logic [NW-1:0] dvd_next [3];
    logic [NW-1:0] dvd_reg  [3];
    logic [DW-1:0] dvs_reg;
    side_t         side_next;
    side_t         side6_reg;

    always_comb
    begin
        den_mag = res_reg[3][DW-1] ? DW'(-res_reg[3]) : res_reg[3];
        for (int r = 0; r < 3; r++)
        begin
            num_mag[r]  = res_reg[r][DW-1] ? DW'(-res_reg[r]) : res_reg[r];
            dvd_next[r] = (NW'(num_mag[r]) << FRAC_BITS) + NW'(den_mag >> 1);
            side_next.neg[r] = res_reg[r][DW-1] ^ res_reg[3][DW-1];
        end
        for (int r = 0; r < 4; r++)
        begin
            side_next.res[r] = res_reg[r];
        end
        side_next.proj = proj5_reg;
        side_next.sat  = sat5_reg;
        side_next.zero = (res_reg[3] == '0);
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        dvs_reg   <= den_mag;
        side6_reg <= side_next;
    end

    // ------------------------------------------------------------------
    // Divider pipelines, one per coordinate, with a matching side line.
    // ------------------------------------------------------------------
    logic [NW-1:0] quo [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        vtd_div #(
            .NW (NW)
        ) u_div (
            .clk      (clk),
            .dividend (dvd_reg[g]),
            .divisor  (dvs_reg),
            .quotient (quo[g])
        );
    end

    side_t side_reg [NW];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side6_reg;
        for (int i = 1; i < NW; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Final stage: sign, clip, zero-divisor handling.
    // ------------------------------------------------------------------
    side_t         fs;
    logic [DW-1:0] fin_next [3];
    logic [2:0]    fsat_next;

    always_comb
    begin
        fs = side_reg[NW-1];
        for (int r = 0; r < 3; r++)
        begin
            fsat_next[r] = 1'b0;
            if (!fs.proj)
            begin
                fin_next[r] = fs.res[r];
            end
            else if (fs.zero)
            begin
                // divide by zero: push to the rail matching the numerator sign; zero stays zero
                if (fs.res[r] == '0)
                begin
                    fin_next[r] = '0;
                end
                else
                begin
                    fin_next[r]  = fs.res[r][DW-1] ? MIN32 : MAX32;
                    fsat_next[r] = 1'b1;
                end
            end
            else if (fs.neg[r])
            begin
                if (quo[r] > QMAX_N)
                begin
                    fin_next[r]  = MIN32;
                    fsat_next[r] = 1'b1;
                end
                else
                begin
                    fin_next[r] = ~quo[r][DW-1:0] + DW'(1);
                end
            end
            else
            begin
                if (quo[r] > QMAX_P)
                begin
                    fin_next[r]  = MAX32;
                    fsat_next[r] = 1'b1;
                end
                else
                begin
                    fin_next[r] = quo[r][DW-1:0];
                end
            end
        end
    end

    // valid line: stages 1..6, divider stages, output register
    localparam int VLEN = 6 + NW + 1;
    logic [VLEN-1:0] valid_reg;
    logic [VLEN-1:0] valid_next;

    assign valid_next = {valid_reg[VLEN-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    logic          last_valid;
    logic [DW-1:0] outx_reg;
    logic [DW-1:0] outy_reg;
    logic [DW-1:0] outz_reg;
    logic [DW-1:0] outw_reg;
    logic          zdiv_reg;
    logic          sat_reg;

    assign last_valid = valid_reg[VLEN-2];

    always_ff @(posedge clk)
    begin
        outx_reg <= fin_next[0];
        outy_reg <= fin_next[1];
        outz_reg <= fin_next[2];
        outw_reg <= fs.res[3];
        // flags only ever show alongside done
        zdiv_reg <= last_valid && fs.proj && fs.zero;
        sat_reg  <= last_valid && (fs.sat || (|fsat_next));
    end

    assign done         = valid_reg[VLEN-1];
    assign out_x        = outx_reg;
    assign out_y        = outy_reg;
    assign out_z        = outz_reg;
    assign out_w        = outw_reg;
    assign zero_divisor = zdiv_reg;
    assign saturated    = sat_reg;

endmodule

// ----- hdl/vtd_checker.sv -----
// ============================================================================
// vtd_checker
// Port-level checks on the vertex transform results.
// ============================================================================
`include "vertex_transform_with_divide_macros.svh"

module vtd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              done,
    input logic signed [vtd_pkg::DATA_W-1:0] out_x,
    input logic signed [vtd_pkg::DATA_W-1:0] out_w,
    input logic                              zero_divisor,
    input logic                              saturated
);

    `VTD_ASSERT_NOW(a_flags_need_done, clk, rst_n, !done, !zero_divisor && !saturated, "flag without done")
    `VTD_ASSERT_NOW(a_zdiv_w_zero, clk, rst_n, zero_divisor, out_w == '0, "zero divisor with nonzero w")
    `VTD_ASSERT_NOW(a_zdiv_rail, clk, rst_n, zero_divisor, (out_x == '0) || (out_x == 32'sh7FFF_FFFF) || (out_x == -32'sh8000_0000), "zero divisor x off rail")
    `VTD_ASSERT_NOW(a_zdiv_sat, clk, rst_n, zero_divisor && (out_x != '0), saturated, "railed x not flagged")

endmodule

bind vertex_transform_with_divide vtd_checker u_vtd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (done),
    .out_x        (out_x),
    .out_w        (out_w),
    .zero_divisor (zero_divisor),
    .saturated    (saturated)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex transform with divide: testbench
// Sends vertex requests through the 4x4 fixed-point transform with random
// start gaps and a series of matrix settings. A local transform model
// predicts every result, and a monitor checks each done strobe against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAC    = 16;
    localparam int LATENCY = 39 + FRAC;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] x, y, z, w;
        logic        zdiv, sat;
    } vertex_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
    logic row_vector = 1'b0, project = 1'b0;
    logic done;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic zero_divisor, saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vtd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vtd_pkg::CFG_W-1:0] cfg_data = '0;

    // Local copy of the matrix registers.
    logic [vtd_pkg::CFG_W-1:0] matrix_regs [vtd_pkg::NUM_REGS];
    vertex_out_t pending_vertices [$];
    int n_mismatch = 0;
    int n_checked  = 0;
    int n_sent     = 0;

    always #10 clk = ~clk;

    vertex_transform_with_divide #(.FRAC_BITS(FRAC)) dut (
        .clk, .rst_n, .start, .busy, .in_x, .in_y, .in_z, .in_w,
        .row_vector, .project, .done, .out_x, .out_y, .out_z, .out_w,
        .zero_divisor, .saturated, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    function automatic longint mat_entry(int r, int c);
        logic [vtd_pkg::CFG_W-1:0] reg_val;
        reg_val = matrix_regs[r * 2 + c / 2];
        return longint'($signed(c % 2 ? reg_val[63:32] : reg_val[31:0]));
    endfunction

    function automatic longint clip(longint v, inout logic sat);
        if (v > S_MAX) begin sat = 1'b1; return S_MAX; end
        if (v < S_MIN) begin sat = 1'b1; return S_MIN; end
        return v;
    endfunction

    // Sum of four exact products, rounded half up at FRAC. The sum fits in
    // 128 bits, so an arithmetic shift of the rounded sum is exact.
    function automatic longint dot_round(longint a[4], longint b[4]);
        logic signed [127:0] acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += 128'(a[k]) * 128'(b[k]);
        acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (acc > 128'(S_MAX) * 4) return S_MAX + 1;
        if (acc < 128'(S_MIN) * 4) return S_MIN - 1;
        return longint'(acc);
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function automatic longint div_round(longint num, longint den);
        logic [63:0] n, d, q;
        logic neg;
        neg = (num < 0) != (den < 0);
        n = 64'(num < 0 ? -num : num) << FRAC;
        d = 64'(den < 0 ? -den : den);
        q = (n + (d >> 1)) / d;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic vertex_out_t transform_vertex(
        logic [31:0] x, y, z, w, logic rowv, logic proj);
        vertex_out_t o;
        longint v[4], a[4], res[4], fin[3];
        logic sat;
        sat = 1'b0;
        v[0] = longint'($signed(x));
        v[1] = longint'($signed(y));
        v[2] = longint'($signed(z));
        v[3] = proj ? longint'(ONE_Q) : longint'($signed(w));
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++)
                a[c] = rowv ? mat_entry(c, r) : mat_entry(r, c);
            res[r] = clip(dot_round(a, v), sat);
        end
        o.zdiv = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (!proj)
                fin[r] = res[r];
            else if (res[3] == 0) begin
                // zero w: numerator sign picks the rail; a zero numerator stays zero
                o.zdiv = 1'b1;
                fin[r] = res[r] > 0 ? S_MAX : (res[r] < 0 ? S_MIN : 0);
                if (res[r] != 0) sat = 1'b1;
            end else
                fin[r] = clip(div_round(res[r], res[3]), sat);
        end
        o.x = 32'(fin[0]); o.y = 32'(fin[1]); o.z = 32'(fin[2]);
        o.w = 32'(res[3]);
        o.sat = sat;
        return o;
    endfunction

    // Result monitor: every done pulse pops the oldest prediction.
    always @(posedge clk) begin
        vertex_out_t got, want;
        if (rst_n && done) begin
            got = '{out_x, out_y, out_z, out_w, zero_divisor, saturated};
            if (pending_vertices.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_vertices.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: exp x=%h y=%h z=%h w=%h zd=%b s=%b",
                                 n_checked, want.x, want.y, want.z, want.w,
                                 want.zdiv, want.sat,
                                 "\n             got x=%h y=%h z=%h w=%h zd=%b s=%b",
                                 got.x, got.y, got.z, got.w, got.zdiv, got.sat);
                end
            end
        end
    end

    // One request with a random lead-in gap; start stays high after the
    // accepting edge so back-to-back requests need no gap.
    task automatic send_vertex(logic [31:0] x, y, z, w, logic rowv, logic proj);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_x <= x; in_y <= y; in_z <= z; in_w <= w;
        row_vector <= rowv; project <= proj;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_vertices.push_back(transform_vertex(x, y, z, w, rowv, proj));
        n_sent++;
    endtask

    // Stop requests, drain outstanding results, then give the pipeline its
    // full depth.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(int idx, logic [vtd_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= vtd_pkg::CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx < vtd_pkg::NUM_REGS) matrix_regs[idx] = val;
    endtask

    task automatic load_matrix(logic [vtd_pkg::CFG_W-1:0] vals[vtd_pkg::NUM_REGS]);
        wait_idle();
        foreach (vals[i]) write_reg(i, vals[i]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            3: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 18'h3FFFF)) - 32'sh20000);
            2: return 32'h0;
            default: return 32'($signed($urandom_range(0, 22'h3FFFFF)) - 32'sh200000);
        endcase
    endfunction

    // Directed corners on the identity matrix.
    task automatic test_identity_corners();
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_vertex(32'h0002_8000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    1'b0, 1'b1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
        send_vertex(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                    1'b0, 1'b0);
    endtask

    // Matrix with a zero w row: project mode hits the zero-divisor rails.
    task automatic test_zero_divisor();
        logic [vtd_pkg::CFG_W-1:0] m[vtd_pkg::NUM_REGS];
        m = '{64'h1, 64'h0, 64'h0000_0000_0000_0000, 64'h0, 64'h0, 64'h0,
              64'h0, 64'h0};
        m[0] = {32'h0, ONE_Q}; m[2] = {32'hFFFF_0000, 32'h0}; m[5] = '0;
        load_matrix(m);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h5, 1'b0, 1'b1);
        send_vertex(32'h0, 32'h0, 32'h1234, 32'h0, 1'b0, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    endtask

    // Extreme entries: large products drive the sums into clipping, divide rounds.
    task automatic test_extreme_matrix();
        logic [vtd_pkg::CFG_W-1:0] m[vtd_pkg::NUM_REGS];
        foreach (m[i]) m[i] = i % 2 ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000;
        m[6] = 64'h0000_0000_0000_0000;
        m[7] = {32'h0, 32'h0000_0003};
        load_matrix(m);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    1'b0, 1'b0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 1'b1, 1'b0);
        send_vertex(32'h0000_8000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        foreach (m[i]) m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        load_matrix(m);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_vertex(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    endtask

    // Random matrices, then a burst of random vertices for each.
    task automatic test_random_stream();
        logic [vtd_pkg::CFG_W-1:0] m[vtd_pkg::NUM_REGS];
        for (int phase = 0; phase < 12; phase++) begin
            foreach (m[i]) m[i] = {rand_entry(), rand_entry()};
            // keep w row projective-friendly half the time
            if (phase % 2) begin
                m[6] = {rand_entry(), 32'h0};
                m[7] = {32'($urandom_range(1, 32'h40000)), 32'h0};
            end
            load_matrix(m);
            for (int k = 0; k < 160; k++)
                send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            1'($urandom), 1'($urandom));
        end
        // Back-to-back stretch with no gaps on the identity; an out-of-range
        // index write rides along and must be dropped.
        m = '{{32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}, 64'h0,
              64'h0, {32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}};
        wait_idle();
        foreach (m[i]) write_reg(i, m[i]);
        write_reg(vtd_pkg::NUM_REGS + 3, 64'hDEAD_BEEF_DEAD_BEEF);
        cfg_valid <= 1'b0;
        start <= 1'b1;
        for (int k = 0; k < 60; k++) begin
            logic [31:0] x, y, z, w;
            logic rv, pj;
            x = rand_coord(); y = rand_coord(); z = rand_coord(); w = rand_coord();
            rv = 1'($urandom); pj = 1'($urandom);
            in_x <= x; in_y <= y; in_z <= z; in_w <= w;
            row_vector <= rv; project <= pj;
            @(posedge clk);
            while (busy) @(posedge clk);
            pending_vertices.push_back(transform_vertex(x, y, z, w, rv, pj));
            n_sent++;
        end
    endtask

    initial begin
        matrix_regs = '{{32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}, 64'h0,
                        64'h0, {32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_identity_corners();
        test_zero_divisor();
        test_extreme_matrix();
        test_random_stream();
        wait_idle();
        $display("Sent %0d vertex requests over 17 matrix settings; %0d results checked.",
                 n_sent, n_checked);
        if (n_mismatch == 0 && pending_vertices.size() == 0)
            $display("** vertex_transform_with_divide: PASSED **");
        else
            $display("** vertex_transform_with_divide: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #(20ns * 400000);
        $display("** vertex_transform_with_divide: FAILED **");
        $finish;
    end

endmodule
